FILE: hw/rtl/wildcard_pattern_matcher_defines.svh
// Assertion macros shared by the wildcard pattern matcher modules.
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
// Expects clk and rst_n in the enclosing scope.
`define WPM_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/wpm_pkg.sv
// Types and constants of the wildcard pattern matcher.
`timescale 1ns / 1ps

package wpm_pkg;

    // Operation codes of an input word
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_SUBJECT = 1'b1;

    // Wildcard bytes in a pattern
    localparam logic [7:0] SYM_STAR     = 8'd42;
    localparam logic [7:0] SYM_QUESTION = 8'd63;

    // One input word as held in the input register
    typedef struct packed {
        logic       operation;
        logic [7:0] symbol;
        logic       is_empty;
        logic       last;
    } item_t;

    // Result of one step of the matching core
    typedef struct packed {
        logic valid;
        logic matched;
        logic pattern_overflow;
    } core_out_t;

endpackage

FILE: hw/rtl/wpm_if.sv
// Valid/ready channel interfaces of the wildcard pattern matcher.
`timescale 1ns / 1ps

interface wpm_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] symbol;
    logic       is_empty;
    logic       last;

    modport source (output valid, operation, symbol, is_empty, last, input ready);
    modport sink   (input valid, operation, symbol, is_empty, last, output ready);
endinterface

interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, matched, pattern_overflow, input ready);
    modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

FILE: hw/rtl/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: input register, matching core, result register.
`timescale 1ns / 1ps
`include "wildcard_pattern_matcher_defines.svh"

// Wildcard pattern matcher. Send a pattern one byte per word (operation 0, '*' any run,
// '?' any one byte, last marks its end), then subject bytes (operation 1); the final or
// empty subject word yields one result word telling whether the whole subject matches the
// whole stored pattern, plus a flag if the pattern was cut to MAX_PATTERN bytes. The block
// takes one word every cycle while result words are taken. The accepting edge loads the
// input register; the result register loads when a final or empty subject word advances
// from it, which waits while an earlier result word is not yet taken. The update of the
// reached position set, a parallel prefix over star runs of ceil(log2(MAX_PATTERN+1))
// levels, sets the cycle time. No clearing pass follows reset.
module wildcard_pattern_matcher
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    wpm_in_if.sink     items,
    wpm_out_if.source  results
);

    logic      s1_valid_reg, s1_valid_next;
    item_t     s1_item_reg;
    logic      s1_go;
    logic      out_valid_reg, out_valid_next;
    logic      out_matched_reg;
    logic      out_ovf_reg;
    core_out_t core_res;

    // Advance the held word unless its result would overwrite one not yet taken
    always_comb
    begin
        s1_go = s1_valid_reg &&
                (!core_res.valid || !out_valid_reg || results.ready);
        items.ready    = !s1_valid_reg || s1_go;
        s1_valid_next  = items.valid ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        if (items.valid && !items.ready)
        begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_go && core_res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    wpm_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_go),
        .item    (s1_item_reg),
        .res     (core_res)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word and the result word
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            s1_item_reg.operation <= items.operation;
            s1_item_reg.symbol    <= items.symbol;
            s1_item_reg.is_empty  <= items.is_empty;
            s1_item_reg.last      <= items.last;
        end
        if (s1_go && core_res.valid)
        begin
            out_matched_reg <= core_res.matched;
            out_ovf_reg     <= core_res.pattern_overflow;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.matched          = out_matched_reg;
    assign results.pattern_overflow = out_ovf_reg;

    `WPM_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_go, s1_valid_reg,
                     "held word dropped")
    `WPM_ASSERT_IMPLIES(a_no_overwrite, out_valid_reg && !results.ready,
                        !(s1_go && core_res.valid), "result overwritten")
    `WPM_ASSERT_IMPLIES(a_stall_cause, s1_valid_reg && !s1_go,
                        out_valid_reg && !results.ready, "word stalled without cause")

endmodule

FILE: hw/rtl/wpm_core.sv
// Pattern store and bit-parallel position-set update of the wildcard pattern matcher.
`timescale 1ns / 1ps
`include "wildcard_pattern_matcher_defines.svh"

module wpm_core
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  item_t     item,
    output core_out_t res
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Pattern bytes, written at most once per pattern word, no reset
    logic [7:0]         store_reg [MAX_PATTERN];
    logic               store_we;

    logic [LEN_W-1:0]   len_reg, len_next;
    logic [MAX_PATTERN:0] lead_reg, lead_next;     // start set closed over leading stars
    logic [MAX_PATTERN:0] active_reg, active_next;  // reached set, closed over stars
    logic               start_reg, start_next;     // reached set is the start set
    logic               ovf_reg, ovf_next;
    logic               loading_reg, loading_next;

    logic [MAX_PATTERN-1:0] star_mask;
    logic [MAX_PATTERN-1:0] hit_mask;
    logic [MAX_PATTERN:0]   cur_set;
    logic [MAX_PATTERN:0]   moved_set;
    logic [MAX_PATTERN:0]   clo_x;
    logic [MAX_PATTERN:0]   clo_p;
    logic [MAX_PATTERN:0]   closed_set;

    logic                 base_clear;
    logic [LEN_W-1:0]     base_len;
    logic [MAX_PATTERN:0] lead_base;
    logic [MAX_PATTERN:0] lead_app;
    logic                 room;
    logic                 sym_star;

    // Classify stored bytes against the current subject byte
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            star_mask[i] = (LEN_W'(i) < len_reg) && (store_reg[i] == SYM_STAR);
            hit_mask[i]  = (LEN_W'(i) < len_reg) && (store_reg[i] != SYM_STAR) &&
                           ((store_reg[i] == SYM_QUESTION) || (store_reg[i] == item.symbol));
        end
    end

    // Advance the reached set by one byte
    always_comb
    begin
        cur_set   = start_reg ? lead_reg : active_reg;
        moved_set = {1'b0, cur_set[MAX_PATTERN-1:0] & star_mask}
                  | {cur_set[MAX_PATTERN-1:0] & hit_mask, 1'b0};
    end

    // Close the new set over stars with a parallel prefix
    always_comb
    begin
        clo_x = moved_set;
        clo_p = {star_mask, 1'b0};
        for (int k = 0; k < LEN_W; k++)
        begin
            clo_x = clo_x | (clo_p & (clo_x << (1 << k)));
            clo_p = clo_p & (clo_p << (1 << k));
        end
        closed_set = clo_x;
    end

    // Append a pattern byte and extend the leading-star run
    always_comb
    begin
        base_clear = loading_reg || item.is_empty;
        base_len   = base_clear ? '0 : len_reg;
        lead_base  = base_clear ? (MAX_PATTERN + 1)'(1) : lead_reg;
        room       = base_len < LEN_W'(MAX_PATTERN);
        sym_star   = item.symbol == SYM_STAR;
        lead_app[0] = lead_base[0];
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            lead_app[i+1] = lead_base[i+1] ||
                            (room && (base_len == LEN_W'(i)) && lead_base[i] && sym_star);
        end
    end

    // Next state
    always_comb
    begin
        len_next     = len_reg;
        lead_next    = lead_reg;
        active_next  = active_reg;
        start_next   = start_reg;
        ovf_next     = ovf_reg;
        loading_next = loading_reg;
        store_we     = 1'b0;
        if (step_en)
        begin
            if (item.operation == OP_PATTERN)
            begin
                start_next = 1'b1;
                if (item.is_empty)
                begin
                    len_next     = '0;
                    ovf_next     = 1'b0;
                    loading_next = 1'b1;
                    lead_next    = (MAX_PATTERN + 1)'(1);
                end
                else
                begin
                    loading_next = item.last;
                    lead_next    = lead_app;
                    if (room)
                    begin
                        store_we = 1'b1;
                        len_next = base_len + LEN_W'(1);
                        ovf_next = base_clear ? 1'b0 : ovf_reg;
                    end
                    else
                    begin
                        len_next = base_len;
                        ovf_next = 1'b1;
                    end
                end
            end
            else
            begin
                loading_next = 1'b1;
                if (item.is_empty || item.last)
                begin
                    start_next = 1'b1;
                end
                else
                begin
                    active_next = closed_set;
                    start_next  = 1'b0;
                end
            end
        end
    end

    // Result of a final or empty subject word
    always_comb
    begin
        res.valid            = (item.operation == OP_SUBJECT) && (item.is_empty || item.last);
        res.matched          = item.is_empty ? lead_reg[len_reg] : closed_set[len_reg];
        res.pattern_overflow = ovf_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            lead_reg    <= (MAX_PATTERN + 1)'(1);
            active_reg  <= (MAX_PATTERN + 1)'(1);
            start_reg   <= 1'b1;
            ovf_reg     <= 1'b0;
            loading_reg <= 1'b1;
        end
        else
        begin
            len_reg     <= len_next;
            lead_reg    <= lead_next;
            active_reg  <= active_next;
            start_reg   <= start_next;
            ovf_reg     <= ovf_next;
            loading_reg <= loading_next;
        end
    end

    // Pattern store
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (store_we && (base_len == LEN_W'(i)))
            begin
                store_reg[i] <= item.symbol;
            end
        end
    end

    `WPM_ASSERT_IMPLIES(a_len_range, 1'b1, len_reg <= LEN_W'(MAX_PATTERN), "pattern length beyond store")
    `WPM_ASSERT_IMPLIES(a_ovf_full, ovf_reg, len_reg == LEN_W'(MAX_PATTERN), "overflow with store not full")
    `WPM_ASSERT_IMPLIES(a_lead_origin, 1'b1, lead_reg[0], "start set lost position zero")

endmodule
